// ===== design/assert_macros.svh =====
// Assertion macros shared by the vertex layout table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is held.
`define VLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vertex layout table check failed");

// Clocked check that also holds during reset.
`define VLT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vertex layout table check failed");

`endif

// ===== design/vlt_pkg.sv =====
// Shared types, constants and the type size table of the vertex layout table.
`default_nettype none
package vlt_pkg;

  localparam int MAX_ELEMENTS_DEF = 16;
  localparam int NUM_USAGES_DEF   = 16;

  localparam int OFF_W     = 16;
  localparam int TYPE_W    = 5;
  localparam int USAGE_W   = 5;
  localparam int OCC_W     = 4;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 5;
  localparam int STRIDE_W  = 9;

  localparam int TYPE_COUNT = 17;
  localparam logic [STRIDE_W-1:0] CURSOR_MAX = '1;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_TYPE  = 2'd1,
    ST_BAD_USAGE = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                go;
    logic [USAGE_W-1:0]  usage;
    logic [OCC_W-1:0]    occ;
  } scan_cmd_t;

  typedef struct packed {
    logic                done;
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [OFF_W-1:0]    offset;
    logic [TYPE_W-1:0]   typ;
  } scan_res_t;

  // Byte size of each element type; unknown codes give zero.
  function automatic logic [SIZE_W-1:0] elem_bytes(input logic [TYPE_W-1:0] t);
    logic [SIZE_W-1:0] s;
    s = '0;
    unique case (t)
      5'd0:    s = 5'd4;
      5'd1:    s = 5'd8;
      5'd2:    s = 5'd12;
      5'd3:    s = 5'd16;
      5'd4:    s = 5'd4;
      5'd5:    s = 5'd4;
      5'd6:    s = 5'd4;
      5'd7:    s = 5'd8;
      5'd8:    s = 5'd4;
      5'd9:    s = 5'd4;
      5'd10:   s = 5'd8;
      5'd11:   s = 5'd4;
      5'd12:   s = 5'd8;
      5'd13:   s = 5'd4;
      5'd14:   s = 5'd4;
      5'd15:   s = 5'd4;
      5'd16:   s = 5'd8;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// ===== design/vlt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module vlt_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/vlt_scan.sv =====
// Query sequencer: walks the entry RAM in append order, one compare per cycle.
`default_nettype none
module vlt_scan #(
  parameter int MAX_ELEMENTS = vlt_pkg::MAX_ELEMENTS_DEF,
  parameter int NUM_USAGES   = vlt_pkg::NUM_USAGES_DEF,
  localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1,
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1),
  localparam int UW    = (NUM_USAGES > 1) ? $clog2(NUM_USAGES) : 1,
  localparam int EW    = UW + vlt_pkg::TYPE_W + vlt_pkg::OFF_W
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire vlt_pkg::scan_cmd_t cmd,
  input  wire logic [CNT_W-1:0]   count,
  output logic      [AW-1:0]      rd_addr,
  input  wire logic [EW-1:0]      rd_data,
  output vlt_pkg::scan_res_t      res
);
  import vlt_pkg::*;

  localparam int SW = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  typedef enum logic {S_IDLE, S_RUN} scan_state_t;

  scan_state_t       state_r;
  logic [CNT_W-1:0]  issue_r, seen_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic [UW-1:0]     usage_r;
  logic [OCC_W-1:0]  occ_r;
  scan_res_t         res_r;

  logic              issue_go, hit, take, miss;
  logic [UW-1:0]     rd_usage;

  assign issue_go = (issue_r < count);
  assign rd_addr  = issue_r[AW-1:0];
  assign rd_usage = rd_data[EW-1 -: UW];
  assign hit      = rd_vld_r && (rd_usage == usage_r);
  assign take     = hit && (SW'(seen_r) == SW'(occ_r));
  // nothing in flight and nothing left to read
  assign miss     = !rd_vld_r && !issue_go;
  assign res      = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      rd_vld_r  <= 1'b0;
      res_r.done <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          rd_vld_r   <= 1'b0;
          res_r.done <= 1'b0;
          if (cmd.go) begin
            state_r <= S_RUN;
            issue_r <= '0;
            seen_r  <= '0;
            usage_r <= cmd.usage[UW-1:0];
            occ_r   <= cmd.occ;
          end
        end
        S_RUN: begin
          rd_vld_r   <= issue_go && !take;
          rd_idx_r   <= issue_r[AW-1:0];
          issue_r    <= issue_r + CNT_W'(issue_go);
          seen_r     <= seen_r + CNT_W'(hit);
          res_r.done <= take || miss;
          if (take || miss) begin
            state_r      <= S_IDLE;
            res_r.found  <= take;
            res_r.idx    <= take ? IDX_W'(rd_idx_r) : '0;
            res_r.offset <= take ? rd_data[OFF_W-1:0] : '0;
            res_r.typ    <= take ? rd_data[OFF_W +: TYPE_W] : '0;
          end
        end
        default: begin
          state_r    <= S_IDLE;
          res_r.done <= 1'b0;
        end
      endcase
    end
  end

`include "assert_macros.svh"
  `VLT_ASSERT(a_rd_in_range, rd_vld_r |-> (CNT_W'(rd_idx_r) < count))
  `VLT_ASSERT(a_done_ends_run, res_r.done |-> (state_r == S_IDLE))

endmodule
`default_nettype wire

// ===== design/vertex_layout_table.sv =====
// Vertex layout table: append and occurrence query over a small element store.
// Append: result strobed in the cycle after the start transfer; busy stays low.
// Query: busy while the entries are scanned (one RAM read and compare per entry),
//   result strobed on the cycle busy drops.
// Bad-usage queries answer like appends. Results cannot be stalled.
// Synchronous reset empties the table (count and cursor to zero); no clearing pass.
`default_nettype none
module vertex_layout_table #(
  parameter int MAX_ELEMENTS = vlt_pkg::MAX_ELEMENTS_DEF,
  parameter int NUM_USAGES   = vlt_pkg::NUM_USAGES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_operation,
  input  wire logic [vlt_pkg::TYPE_W-1:0]      in_elem_type,
  input  wire logic [vlt_pkg::USAGE_W-1:0]     in_usage_class,
  input  wire logic                            in_use_explicit_offset,
  input  wire logic [vlt_pkg::OFF_W-1:0]       in_explicit_offset,
  input  wire logic [vlt_pkg::OCC_W-1:0]       in_occurrence,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic                                 out_found,
  output logic [vlt_pkg::IDX_W-1:0]            out_match_index,
  output logic [vlt_pkg::OFF_W-1:0]            out_match_offset,
  output logic [vlt_pkg::TYPE_W-1:0]           out_match_type,
  output logic [vlt_pkg::SIZE_W-1:0]           out_match_size,
  output logic [vlt_pkg::STRIDE_W-1:0]         out_vertex_stride
);
  import vlt_pkg::*;

  localparam int AW    = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int UW    = (NUM_USAGES > 1) ? $clog2(NUM_USAGES) : 1;
  localparam int EW    = UW + TYPE_W + OFF_W;

  typedef enum logic {T_IDLE, T_SCAN} top_state_t;

  top_state_t            state_r;
  logic [CNT_W-1:0]      count_r;
  logic [STRIDE_W-1:0]   cursor_r, cursor_nxt;
  logic                  out_valid_r;
  status_t               status_r;
  logic                  found_r;
  logic [IDX_W-1:0]      idx_r;
  logic [OFF_W-1:0]      moff_r;
  logic [TYPE_W-1:0]     mtyp_r;
  logic [SIZE_W-1:0]     msize_r;
  logic [STRIDE_W-1:0]   stride_r;

  logic                  accept, usage_bad, type_bad, full, do_write;
  logic [SIZE_W-1:0]     bytes;
  logic [STRIDE_W:0]     cursor_sum;
  logic [OFF_W-1:0]      wr_off;
  logic [EW-1:0]         wr_data, rd_data;
  logic [AW-1:0]         rd_addr;
  scan_cmd_t             scan_cmd;
  scan_res_t             scan_res;

  assign busy      = (state_r == T_SCAN);
  assign accept    = start && !busy;
  assign usage_bad = ({1'b0, in_usage_class} >= (USAGE_W + 1)'(NUM_USAGES));
  assign type_bad  = (in_elem_type >= TYPE_W'(TYPE_COUNT));
  assign full      = (count_r >= CNT_W'(MAX_ELEMENTS));
  assign do_write  = accept && (in_operation == OP_APPEND) && !usage_bad && !type_bad && !full;
  assign bytes     = elem_bytes(in_elem_type);

  assign cursor_sum = {1'b0, cursor_r} + (STRIDE_W + 1)'(bytes);
  assign cursor_nxt = cursor_sum[STRIDE_W] ? CURSOR_MAX : cursor_sum[STRIDE_W-1:0];

  assign wr_off  = in_use_explicit_offset ? in_explicit_offset : OFF_W'(cursor_r);
  assign wr_data = {in_usage_class[UW-1:0], in_elem_type, wr_off};

  assign scan_cmd.go    = accept && (in_operation == OP_QUERY) && !usage_bad;
  assign scan_cmd.usage = in_usage_class;
  assign scan_cmd.occ   = in_occurrence;

  vlt_ram #(.W(EW), .D(MAX_ELEMENTS)) u_entries (
    .clk   (clk),
    .we    (do_write),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  vlt_scan #(.MAX_ELEMENTS(MAX_ELEMENTS), .NUM_USAGES(NUM_USAGES)) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (scan_cmd),
    .count   (count_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .res     (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        T_IDLE: begin
          // appends and bad-usage queries answer on the next cycle
          out_valid_r <= accept && ((in_operation == OP_APPEND) || usage_bad);
          if (accept) begin
            found_r  <= 1'b0;
            idx_r    <= '0;
            moff_r   <= '0;
            mtyp_r   <= '0;
            msize_r  <= '0;
            stride_r <= do_write ? cursor_nxt : cursor_r;
            if (in_operation == OP_APPEND) begin
              priority if (usage_bad) begin
                status_r <= ST_BAD_USAGE;
              end else if (type_bad) begin
                status_r <= ST_BAD_TYPE;
              end else if (full) begin
                status_r <= ST_FULL;
              end else begin
                status_r <= ST_OK;
                count_r  <= count_r + 1'b1;
                cursor_r <= cursor_nxt;
              end
            end else if (usage_bad) begin
              status_r    <= ST_BAD_USAGE;
            end else begin
              state_r <= T_SCAN;
            end
          end
        end
        T_SCAN: begin
          out_valid_r <= scan_res.done;
          if (scan_res.done) begin
            state_r     <= T_IDLE;
            status_r    <= ST_OK;
            found_r     <= scan_res.found;
            idx_r       <= scan_res.idx;
            moff_r      <= scan_res.offset;
            mtyp_r      <= scan_res.typ;
            msize_r     <= scan_res.found ? elem_bytes(scan_res.typ) : '0;
            stride_r    <= cursor_r;
          end
        end
        default: begin
          state_r     <= T_IDLE;
          out_valid_r <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_found         = found_r;
  assign out_match_index   = idx_r;
  assign out_match_offset  = moff_r;
  assign out_match_type    = mtyp_r;
  assign out_match_size    = msize_r;
  assign out_vertex_stride = stride_r;

`include "assert_macros.svh"
  `VLT_ASSERT(a_count_bound, count_r <= CNT_W'(MAX_ELEMENTS))
  `VLT_ASSERT(a_scan_table_frozen, busy |=> $stable(count_r) && $stable(cursor_r))
  `VLT_ASSERT(a_scan_done_strobes, (busy && scan_res.done) |=> (out_valid && !busy))
  `VLT_ASSERT(a_found_only_ok, (out_valid && out_found) |-> (out_status == ST_OK))

endmodule
`default_nettype wire
